// ===== rtl/igmt_pkg.sv =====
// Shared constants for the multicast group membership table.
`default_nettype none
package igmt_pkg;
    localparam int CMD_W         = 3;
    localparam int ACT_W         = 3;
    localparam int ADDR_W        = 32;
    localparam int MARK_W        = 32;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;
    localparam int DEF_DEPTH     = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int RES_CNT_W     = 5;

    localparam logic [CMD_W-1:0] CMD_REPORT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LEAVE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SWEEP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd4;

    localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REPORT  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_LEAVE   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FORWARD = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DROP    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_FLAG = 1'd1;

    localparam logic [MARK_W-1:0] WLAN_MARK      = 32'h0001_0000;
    localparam logic [MARK_W-1:0] WLAN_NONE_MARK = 32'h1000_0000;
endpackage
`default_nettype wire

// ===== rtl/igmt_req_if.sv =====
// Request channel: one command word per handshake.
`default_nettype none
interface igmt_req_if;
    logic                        valid;
    logic                        ready;
    logic [igmt_pkg::CMD_W-1:0]  command;
    logic [igmt_pkg::ADDR_W-1:0] group_addr;
    logic [igmt_pkg::MARK_W-1:0] port_mark;
    modport source (output valid, command, group_addr, port_mark, input ready);
    modport sink   (input valid, command, group_addr, port_mark, output ready);
endinterface
`default_nettype wire

// ===== rtl/igmt_rsp_if.sv =====
// Response channel: one result word per handshake.
`default_nettype none
interface igmt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [igmt_pkg::ACT_W-1:0]  action;
    logic [igmt_pkg::ADDR_W-1:0] out_group;
    logic [igmt_pkg::MARK_W-1:0] forward_mark;
    logic                        last;
    modport source (output valid, action, out_group, forward_mark, last, input ready);
    modport sink   (input valid, action, out_group, forward_mark, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/igmp_group_membership_table_core.sv =====
// Top level of the multicast group membership table.
`default_nettype none
// Multicast group membership table. Group address and port mask of each slot
// live in a single-port-read, single-port-write table RAM (registered read
// data); slot used and reported bits sit in flops. Free slots come from a
// LIFO held in a second small RAM. One command word is handled at a time:
// report, leave and lookup walk the table RAM one slot per cycle (a report
// that inserts also reads the LIFO). Aging sweep and flush read and check
// each slot in turn and wait if the response side stalls. With the block
// disabled every word gives one drop. Results leave through an output
// register; at most 16 results per command, the last one flagged. No
// clearing pass after reset.
module igmp_group_membership_table_core
#(
    parameter int TABLE_DEPTH = igmt_pkg::DEF_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [igmt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [igmt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    igmt_req_if.sink                               req,
    igmt_rsp_if.source                             rsp
);
    import igmt_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = ADDR_W + MARK_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [IW:0]   IDX_END = (IW + 1)'(TABLE_DEPTH);
    localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_DEPTH - 1);
    localparam logic [RES_CNT_W-1:0] RES_MAX = RES_CNT_W'(MAX_RESULTS);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_INS, S_SW_RD, S_SW_CHK, S_SW_END, S_EMIT
    } state_t;

    // config registers
    logic              enable_reg;
    logic [MARK_W-1:0] down_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b1;
            down_flag_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLE:    enable_reg    <= cfg_wdata[0];
                REG_DOWN_FLAG: down_flag_reg <= cfg_wdata[MARK_W-1:0];
                default:       ;
            endcase
        end
    end

    state_t state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [ADDR_W-1:0]    grp_reg, grp_next;
    logic [MARK_W-1:0]    mark_reg, mark_next;
    logic [IW:0]          idx_reg, idx_next;
    logic [TABLE_DEPTH-1:0] used_reg, used_next;
    logic [TABLE_DEPTH-1:0] rep_reg, rep_next;
    logic [TABLE_DEPTH-1:0] stk_wr_reg, stk_wr_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 pop_wr_reg, pop_wr_next;
    logic [IW-1:0]        pop_dflt_reg, pop_dflt_next;
    logic [RES_CNT_W-1:0] n_reg, n_next;
    logic                 pend_reg, pend_next;
    logic [ADDR_W-1:0]    pend_grp_reg, pend_grp_next;
    logic [ACT_W-1:0]     res_act_reg, res_act_next;
    logic [ADDR_W-1:0]    res_grp_reg, res_grp_next;
    logic [MARK_W-1:0]    res_mark_reg, res_mark_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ACT_W-1:0]     out_act_reg, out_act_next;
    logic [ADDR_W-1:0]    out_grp_reg, out_grp_next;
    logic [MARK_W-1:0]    out_mark_reg, out_mark_next;
    logic                 out_last_reg, out_last_next;

    // table RAM and free-slot LIFO RAM
    logic [EW-1:0]   tbl_mem [TABLE_DEPTH];
    logic [EW-1:0]   q_reg;
    logic [IW-1:0]   q_slot_reg;
    logic            q_vld_reg;
    logic [IW-1:0]   stk_mem [TABLE_DEPTH];
    logic [IW-1:0]   stk_q_reg;

    logic            mem_re, mem_we, stk_re, stk_we;
    logic [IW-1:0]   mem_raddr, mem_waddr, stk_raddr, stk_waddr;
    logic [EW-1:0]   mem_wdata;
    logic [IW-1:0]   stk_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            tbl_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
        begin
            q_reg      <= tbl_mem[mem_raddr];
            q_slot_reg <= mem_raddr;
        end
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        if (stk_re)
            stk_q_reg <= stk_mem[stk_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_vld_reg <= 1'b0;
        else
            q_vld_reg <= mem_re;
    end

    logic [ADDR_W-1:0] q_grp;
    logic [MARK_W-1:0] q_mask, leave_mask;
    logic              q_used, q_rep, match, out_free, sw_hit;
    logic [CW-1:0]     pop_sp;
    logic [IW-1:0]     ins_slot;

    assign q_grp   = q_reg[EW-1:MARK_W];
    assign q_mask  = q_reg[MARK_W-1:0];
    assign q_used  = used_reg[q_slot_reg];
    assign q_rep   = rep_reg[q_slot_reg];
    assign match   = q_vld_reg && q_used && (q_grp == grp_reg);
    assign out_free = !out_valid_reg || rsp.ready;
    assign pop_sp  = DEPTH_C - count_reg - CW'(1);
    assign ins_slot = pop_wr_reg ? stk_q_reg : pop_dflt_reg;
    assign sw_hit  = q_used && ((cmd_reg == CMD_FLUSH) || !q_rep);

    // leave: WLAN join mark is ignored, WLAN-none mark drops both WLAN bits
    always_comb
    begin
        if (mark_reg == WLAN_MARK)
            leave_mask = q_mask;
        else if (mark_reg == WLAN_NONE_MARK)
            leave_mask = q_mask & ~(WLAN_MARK | WLAN_NONE_MARK);
        else
            leave_mask = q_mask & ~mark_reg;
    end

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        logic [CW-1:0] push_sp;
        logic          do_free;
        push_sp = DEPTH_C - count_reg;
        do_free = 1'b0;

        state_next    = state_reg;
        cmd_next      = cmd_reg;
        grp_next      = grp_reg;
        mark_next     = mark_reg;
        idx_next      = idx_reg;
        used_next     = used_reg;
        rep_next      = rep_reg;
        stk_wr_next   = stk_wr_reg;
        count_next    = count_reg;
        pop_wr_next   = pop_wr_reg;
        pop_dflt_next = pop_dflt_reg;
        n_next        = n_reg;
        pend_next     = pend_reg;
        pend_grp_next = pend_grp_reg;
        res_act_next  = res_act_reg;
        res_grp_next  = res_grp_reg;
        res_mark_next = res_mark_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_act_next  = out_act_reg;
        out_grp_next  = out_grp_reg;
        out_mark_next = out_mark_reg;
        out_last_next = out_last_reg;

        mem_re    = 1'b0;
        mem_raddr = idx_reg[IW-1:0];
        mem_we    = 1'b0;
        mem_waddr = q_slot_reg;
        mem_wdata = q_reg;
        stk_re    = 1'b0;
        stk_raddr = pop_sp[IW-1:0];
        stk_we    = 1'b0;
        stk_waddr = push_sp[IW-1:0];
        stk_wdata = q_slot_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next     = req.command;
                    grp_next     = req.group_addr;
                    mark_next    = req.port_mark;
                    idx_next     = '0;
                    n_next       = '0;
                    pend_next    = 1'b0;
                    res_grp_next = req.group_addr;
                    res_mark_next = '0;
                    res_act_next = ACT_NONE;
                    if (!enable_reg)
                    begin
                        res_act_next = ACT_DROP;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        case (req.command) inside
                            CMD_REPORT:
                                state_next = (req.group_addr == '0) ? S_EMIT : S_SCAN;
                            CMD_LEAVE, CMD_LOOKUP:
                                state_next = S_SCAN;
                            CMD_SWEEP, CMD_FLUSH:
                                state_next = S_SW_RD;
                            default:
                                state_next = S_EMIT;
                        endcase
                    end
                end
            end

            S_SCAN:
            begin
                if (idx_reg < IDX_END)
                begin
                    mem_re   = 1'b1;
                    idx_next = idx_reg + (IW + 1)'(1);
                end
                if (match)
                begin
                    state_next = S_EMIT;
                    case (cmd_reg)
                        CMD_REPORT:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {q_grp, q_mask | mark_reg};
                            rep_next[q_slot_reg] = 1'b1;
                            res_act_next = ACT_NONE;
                        end
                        CMD_LEAVE:
                        begin
                            if (leave_mask == '0)
                            begin
                                do_free      = 1'b1;
                                res_act_next = ACT_LEAVE;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = {q_grp, leave_mask};
                                res_act_next = ACT_NONE;
                            end
                        end
                        default:
                        begin
                            res_act_next  = ACT_FORWARD;
                            res_mark_next = q_mask | down_flag_reg;
                        end
                    endcase
                end
                else if (q_vld_reg && (q_slot_reg == LAST_SLOT))
                begin
                    // walked the whole table without a hit
                    state_next = S_EMIT;
                    case (cmd_reg)
                        CMD_REPORT:
                        begin
                            res_act_next = ACT_NONE;
                            if (count_reg != DEPTH_C)
                            begin
                                stk_re        = 1'b1;
                                pop_wr_next   = stk_wr_reg[pop_sp[IW-1:0]];
                                pop_dflt_next = count_reg[IW-1:0];
                                state_next    = S_INS;
                            end
                        end
                        CMD_LEAVE: res_act_next = ACT_NONE;
                        default:   res_act_next = ACT_DROP;
                    endcase
                end
            end

            S_INS:
            begin
                mem_we    = 1'b1;
                mem_waddr = ins_slot;
                mem_wdata = {grp_reg, mark_reg};
                used_next[ins_slot] = 1'b1;
                rep_next[ins_slot]  = 1'b1;
                count_next   = count_reg + CW'(1);
                res_act_next = ACT_REPORT;
                state_next   = S_EMIT;
            end

            S_SW_RD:
            begin
                mem_re     = 1'b1;
                idx_next   = idx_reg + (IW + 1)'(1);
                state_next = S_SW_CHK;
            end

            S_SW_CHK:
            begin
                logic advance;
                advance = 1'b1;
                if (sw_hit)
                begin
                    if (n_reg == RES_MAX)
                        do_free = 1'b1;
                    else if (pend_reg)
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_act_next   = ACT_LEAVE;
                            out_grp_next   = pend_grp_reg;
                            out_mark_next  = '0;
                            out_last_next  = 1'b0;
                            pend_grp_next  = q_grp;
                            n_next         = n_reg + RES_CNT_W'(1);
                            do_free        = 1'b1;
                        end
                        else
                            advance = 1'b0;
                    end
                    else
                    begin
                        pend_next     = 1'b1;
                        pend_grp_next = q_grp;
                        n_next        = n_reg + RES_CNT_W'(1);
                        do_free       = 1'b1;
                    end
                end
                if (advance)
                    state_next = (q_slot_reg == LAST_SLOT) ? S_SW_END : S_SW_RD;
            end

            S_SW_END:
            begin
                rep_next      = '0;
                res_act_next  = pend_reg ? ACT_LEAVE : ACT_NONE;
                res_grp_next  = pend_reg ? pend_grp_reg : '0;
                res_mark_next = '0;
                state_next    = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_act_next   = res_act_reg;
                    out_grp_next   = res_grp_reg;
                    out_mark_next  = res_mark_reg;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        // release a slot: clear its bits and push it back on the LIFO
        if (do_free)
        begin
            used_next[q_slot_reg]  = 1'b0;
            rep_next[q_slot_reg]   = 1'b0;
            stk_we                 = 1'b1;
            stk_wr_next[push_sp[IW-1:0]] = 1'b1;
            count_next             = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            rep_reg       <= '0;
            stk_wr_reg    <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            rep_reg       <= rep_next;
            stk_wr_reg    <= stk_wr_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        grp_reg      <= grp_next;
        mark_reg     <= mark_next;
        pop_wr_reg   <= pop_wr_next;
        pop_dflt_reg <= pop_dflt_next;
        pend_grp_reg <= pend_grp_next;
        res_act_reg  <= res_act_next;
        res_grp_reg  <= res_grp_next;
        res_mark_reg <= res_mark_next;
        out_act_reg  <= out_act_next;
        out_grp_reg  <= out_grp_next;
        out_mark_reg <= out_mark_next;
        out_last_reg <= out_last_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.action       = out_act_reg;
    assign rsp.out_group    = out_grp_reg;
    assign rsp.forward_mark = out_mark_reg;
    assign rsp.last         = out_last_reg;
endmodule
`default_nettype wire
